FILE: rtl/cba_pkg.sv
// Shared types and constants for the credit budget accountant.
// No dependencies; imported by every module of the block.
package cba_pkg;

    localparam int CRED_W     = 64;
    localparam int MAX_PHASES = 4;
    localparam int CAUSE_W    = 2;

    typedef enum logic [1:0] {
        REQ_SINGLE,
        REQ_SPLIT,
        REQ_ADD,
        REQ_REINIT
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_REFUSED,
        ST_ERROR
    } status_t;

    // Request as it enters the update stage
    typedef struct packed {
        req_type_t          kind;
        logic               bad_phase;
        logic [CRED_W-1:0]  charge;
        logic               charge_wrap;
        logic               charge_nz;
    } cba_charge_t;

    // Decision of the merge stage
    typedef struct packed {
        status_t status;
        logic    commit;
        logic    refuse;
        logic    add_ok;
        logic    reinit;
    } cba_dec_t;

    typedef struct packed {
        logic commit;
        logic clear;
    } cba_lane_ctl_t;

endpackage

FILE: rtl/cba_lane.sv
// One phase lane: holds the phase's used count and checks its add for wrap.
// Depends on cba_pkg.
module cba_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cba_pkg::cba_lane_ctl_t        ctl,
    input  logic [cba_pkg::CRED_W-1:0]    amt,
    output logic                          wrap,
    output logic [cba_pkg::CRED_W-1:0]    used_next
);
    import cba_pkg::*;

    logic [CRED_W-1:0] used_reg;
    logic [CRED_W:0]   sum;

    assign sum  = {1'b0, used_reg} + {1'b0, amt};
    assign wrap = sum[CRED_W];

    always_comb
    begin
        if (ctl.clear)
        begin
            used_next = '0;
        end
        else if (ctl.commit)
        begin
            used_next = sum[CRED_W-1:0];
        end
        else
        begin
            used_next = used_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

endmodule

FILE: rtl/cba_merge.sv
// Merge stage: combines lane wrap flags with the budget checks into one decision.
// Depends on cba_pkg.
module cba_merge #(
    parameter int PHASES = 4
) (
    input  cba_pkg::cba_charge_t          req,
    input  logic [PHASES-1:0]             lane_wrap,
    input  logic [cba_pkg::CRED_W-1:0]    limit,
    input  logic [cba_pkg::CRED_W-1:0]    total,
    output cba_pkg::cba_dec_t             dec,
    output logic [cba_pkg::CRED_W-1:0]    total_sum,
    output logic [cba_pkg::CRED_W-1:0]    limit_sum
);
    import cba_pkg::*;

    logic [CRED_W:0]   tsum;
    logic [CRED_W:0]   lsum;
    logic [CRED_W+1:0] slack;
    logic              consume_err;
    logic              short;

    assign tsum  = {1'b0, total} + {1'b0, req.charge};
    assign lsum  = {1'b0, limit} + {1'b0, req.charge};
    // limit - total - charge; negative means the charge exceeds what is left
    assign slack = {2'b00, limit} - {2'b00, total} - {2'b00, req.charge};
    assign short = slack[CRED_W+1];

    assign consume_err = req.bad_phase || req.charge_wrap || (|lane_wrap) || tsum[CRED_W];

    assign total_sum = tsum[CRED_W-1:0];
    assign limit_sum = lsum[CRED_W-1:0];

    always_comb
    begin
        dec = '{status: ST_OK, commit: 1'b0, refuse: 1'b0, add_ok: 1'b0, reinit: 1'b0};
        unique case (req.kind)
            REQ_SINGLE, REQ_SPLIT:
            begin
                if (consume_err)
                begin
                    dec.status = ST_ERROR;
                end
                else if (req.charge_nz && short)
                begin
                    dec.status = ST_REFUSED;
                    dec.refuse = 1'b1;
                end
                else
                begin
                    dec.commit = 1'b1;
                end
            end
            REQ_ADD:
            begin
                if (lsum[CRED_W])
                begin
                    dec.status = ST_ERROR;
                end
                else
                begin
                    dec.add_ok = 1'b1;
                end
            end
            REQ_REINIT:
            begin
                dec.reinit = 1'b1;
            end
        endcase
    end

endmodule

FILE: rtl/credit_budget_accountant_core.sv
// Credit budget accountant, top level.
// One request per cycle while out_stall is low; each request passes stages A, B, C and the output stage D.
// The rate is set by the update stage, where the lanes and the merge stage do
// the 64-bit adds and the budget compare that the next request depends on.
// Reset: limit, totals, per-phase counts and the exhausted mark clear to zero;
// the initial limit register resets to zero. Depends on cba_pkg, cba_lane, cba_merge.
module credit_budget_accountant_core #(
    parameter int PHASES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [2:0]  phase,
    input  logic [63:0] credits,
    input  logic [63:0] split_credit_0,
    input  logic [63:0] split_credit_1,
    input  logic [63:0] split_credit_2,
    input  logic [63:0] split_credit_3,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [63:0] remaining,
    output logic        exhausted,
    output logic        exh_cause_valid,
    output logic [1:0]  exh_cause,
    output logic [63:0] used_total,
    output logic [63:0] phase_spent_now,
    output logic [63:0] limit_now
);
    import cba_pkg::*;

    localparam logic [2:0] PHASE_LIM = 3'(PHASES);

    // pipeline flow
    logic a_v_reg, b_v_reg, c_v_reg, o_v_reg;
    logic a_free, b_free, c_free, o_free;
    logic a_load, b_load, c_load, o_load;

    assign o_free = !o_v_reg || !out_stall;
    assign c_free = !c_v_reg || o_free;
    assign b_free = !b_v_reg || c_free;
    assign a_free = !a_v_reg || b_free;

    assign in_stall = !a_free;
    assign a_load   = in_valid && a_free;
    assign b_load   = a_v_reg && b_free;
    assign c_load   = b_v_reg && c_free;
    assign o_load   = c_v_reg && o_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else
        begin
            if (a_free) a_v_reg <= in_valid;
            if (b_free) b_v_reg <= a_v_reg;
            if (c_free) c_v_reg <= b_v_reg;
            if (o_free) o_v_reg <= c_v_reg;
        end
    end

    // stage A: capture, lane masking, pair sums, first nonzero lane
    logic [CRED_W-1:0] lane_in [MAX_PHASES];
    logic [CAUSE_W-1:0] cause_next;

    always_comb
    begin
        lane_in[0] = split_credit_0;
        lane_in[1] = (PHASES > 1) ? split_credit_1 : '0;
        lane_in[2] = (PHASES > 2) ? split_credit_2 : '0;
        lane_in[3] = (PHASES > 3) ? split_credit_3 : '0;
    end

    always_comb
    begin
        cause_next = '0;
        for (int p = MAX_PHASES - 1; p >= 0; p--)
        begin
            if (lane_in[p] != '0)
            begin
                cause_next = CAUSE_W'(p);
            end
        end
    end

    req_type_t          a_kind_reg;
    logic [2:0]         a_phase_reg;
    logic [CRED_W-1:0]  a_credits_reg;
    logic [CRED_W-1:0]  a_lane_reg [PHASES];
    logic [CRED_W:0]    a_sum01_reg;
    logic [CRED_W:0]    a_sum23_reg;
    logic [CAUSE_W-1:0] a_cause_reg;

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_kind_reg    <= req_type_t'(req_type);
            a_phase_reg   <= phase;
            a_credits_reg <= credits;
            for (int p = 0; p < PHASES; p++)
            begin
                a_lane_reg[p] <= lane_in[p];
            end
            a_sum01_reg   <= {1'b0, lane_in[0]} + {1'b0, lane_in[1]};
            a_sum23_reg   <= {1'b0, lane_in[2]} + {1'b0, lane_in[3]};
            a_cause_reg   <= cause_next;
        end
    end

    // stage B: charge amount and per-lane amounts
    logic [CRED_W+1:0]  split_full;
    cba_charge_t        b_req_next;
    logic [CRED_W-1:0]  amt_next [PHASES];
    logic [CAUSE_W-1:0] b_cause_next;

    assign split_full = {1'b0, a_sum01_reg} + {1'b0, a_sum23_reg};

    always_comb
    begin
        b_req_next.kind        = a_kind_reg;
        b_req_next.bad_phase   = (a_kind_reg == REQ_SINGLE) && (a_phase_reg >= PHASE_LIM);
        b_req_next.charge      = a_credits_reg;
        b_req_next.charge_wrap = 1'b0;
        b_req_next.charge_nz   = (a_credits_reg != '0);
        if (a_kind_reg == REQ_SPLIT)
        begin
            b_req_next.charge      = split_full[CRED_W-1:0];
            b_req_next.charge_wrap = |split_full[CRED_W+1:CRED_W];
            b_req_next.charge_nz   = (split_full != '0);
        end
        b_cause_next = (a_kind_reg == REQ_SINGLE) ? a_phase_reg[CAUSE_W-1:0] : a_cause_reg;
        for (int p = 0; p < PHASES; p++)
        begin
            amt_next[p] = '0;
            if (a_kind_reg == REQ_SPLIT)
            begin
                amt_next[p] = a_lane_reg[p];
            end
            else if ((a_kind_reg == REQ_SINGLE) && (a_phase_reg == 3'(p)))
            begin
                amt_next[p] = a_credits_reg;
            end
        end
    end

    cba_charge_t        b_req_reg;
    logic [2:0]         b_phase_reg;
    logic [CRED_W-1:0]  b_amt_reg [PHASES];
    logic [CAUSE_W-1:0] b_cause_reg;

    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            b_req_reg   <= b_req_next;
            b_phase_reg <= a_phase_reg;
            b_cause_reg <= b_cause_next;
            for (int p = 0; p < PHASES; p++)
            begin
                b_amt_reg[p] <= amt_next[p];
            end
        end
    end

    // stage C: lanes, merge, state update
    logic [CRED_W-1:0]  init_reg;
    logic [CRED_W-1:0]  limit_reg, limit_next;
    logic [CRED_W-1:0]  total_reg, total_next;
    logic               exh_reg, exh_next;
    logic               cv_reg, cv_next;
    logic [CAUSE_W-1:0] cp_reg, cp_next;

    logic [PHASES-1:0]  lane_wrap;
    logic [CRED_W-1:0]  used_next [PHASES];
    cba_lane_ctl_t      lane_ctl;
    cba_dec_t           dec;
    logic [CRED_W-1:0]  total_sum;
    logic [CRED_W-1:0]  limit_sum;
    logic [CRED_W-1:0]  phase_spent_next;

    assign lane_ctl.commit = c_load && dec.commit;
    assign lane_ctl.clear  = c_load && dec.reinit;

    for (genvar g = 0; g < PHASES; g++)
    begin : g_lane
        cba_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (lane_ctl),
            .amt       (b_amt_reg[g]),
            .wrap      (lane_wrap[g]),
            .used_next (used_next[g])
        );
    end

    cba_merge #(
        .PHASES (PHASES)
    ) u_merge (
        .req       (b_req_reg),
        .lane_wrap (lane_wrap),
        .limit     (limit_reg),
        .total     (total_reg),
        .dec       (dec),
        .total_sum (total_sum),
        .limit_sum (limit_sum)
    );

    always_comb
    begin
        limit_next = limit_reg;
        total_next = total_reg;
        exh_next   = exh_reg;
        cv_next    = cv_reg;
        cp_next    = cp_reg;
        if (c_load)
        begin
            if (dec.reinit)
            begin
                limit_next = init_reg;
                total_next = '0;
                exh_next   = 1'b0;
                cv_next    = 1'b0;
                cp_next    = '0;
            end
            if (dec.add_ok)
            begin
                limit_next = limit_sum;
                exh_next   = 1'b0;
                cv_next    = 1'b0;
                cp_next    = '0;
            end
            if (dec.commit)
            begin
                total_next = total_sum;
            end
            if (dec.refuse)
            begin
                exh_next = 1'b1;
                cv_next  = 1'b1;
                cp_next  = b_cause_reg;
            end
        end
    end

    always_comb
    begin
        phase_spent_next = '0;
        for (int p = 0; p < PHASES; p++)
        begin
            if (b_phase_reg == 3'(p))
            begin
                phase_spent_next = used_next[p];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg  <= '0;
            limit_reg <= '0;
            total_reg <= '0;
            exh_reg   <= 1'b0;
            cv_reg    <= 1'b0;
            cp_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                init_reg <= cfg_wr_data;
            end
            limit_reg <= limit_next;
            total_reg <= total_next;
            exh_reg   <= exh_next;
            cv_reg    <= cv_next;
            cp_reg    <= cp_next;
        end
    end

    // snapshot of the state after this request
    status_t            c_status_reg;
    logic [CRED_W-1:0]  c_limit_reg;
    logic [CRED_W-1:0]  c_total_reg;
    logic [CRED_W-1:0]  c_phase_spent_reg;
    logic               c_exh_reg;
    logic               c_cv_reg;
    logic [CAUSE_W-1:0] c_cp_reg;

    always_ff @(posedge clk)
    begin
        if (c_load)
        begin
            c_status_reg      <= dec.status;
            c_limit_reg       <= limit_next;
            c_total_reg       <= total_next;
            c_phase_spent_reg <= phase_spent_next;
            c_exh_reg         <= exh_next;
            c_cv_reg          <= cv_next;
            c_cp_reg          <= cp_next;
        end
    end

    // stage D: remaining budget and output register
    logic [CRED_W-1:0]  remaining_next;
    status_t            o_status_reg;
    logic [CRED_W-1:0]  o_remaining_reg;
    logic [CRED_W-1:0]  o_limit_reg;
    logic [CRED_W-1:0]  o_total_reg;
    logic [CRED_W-1:0]  o_phase_spent_reg;
    logic               o_exh_reg;
    logic               o_cv_reg;
    logic [CAUSE_W-1:0] o_cp_reg;

    assign remaining_next = (c_total_reg > c_limit_reg) ? '0 : (c_limit_reg - c_total_reg);

    always_ff @(posedge clk)
    begin
        if (o_load)
        begin
            o_status_reg      <= c_status_reg;
            o_remaining_reg   <= remaining_next;
            o_limit_reg       <= c_limit_reg;
            o_total_reg       <= c_total_reg;
            o_phase_spent_reg <= c_phase_spent_reg;
            o_exh_reg         <= c_exh_reg;
            o_cv_reg          <= c_cv_reg;
            o_cp_reg          <= c_cp_reg;
        end
    end

    assign out_valid       = o_v_reg;
    assign status          = o_status_reg;
    assign remaining       = o_remaining_reg;
    assign exhausted       = o_exh_reg;
    assign exh_cause_valid = o_cv_reg;
    assign exh_cause       = o_cp_reg;
    assign used_total      = o_total_reg;
    assign phase_spent_now = o_phase_spent_reg;
    assign limit_now       = o_limit_reg;

endmodule
